>>> hdl/tmbc_pkg.sv
`default_nettype none

package tmbc_pkg;

    // Default sizes of the map store and of the scan window.
    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLS_DEF    = 64;
    localparam int WINDOW_SPAN_DEF = 4;

    // Window bounds in the command word cover the full map range (up to 511).
    localparam int BOUND_W = 9;

    // Pixel arithmetic: tile index times tile size plus one tile fits here.
    localparam int PIX_W = 20;

    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TILE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_TILE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_MAP_ROWS    = 3'd2;
    localparam logic [2:0] CFG_MAP_COLS    = 3'd3;
    localparam logic [2:0] CFG_SOLID_COUNT = 3'd4;

    localparam logic [10:0] TILE_SIZE_RST   = 11'd32;
    localparam logic [6:0]  MAP_SIZE_RST    = 7'd64;
    localparam logic [6:0]  SOLID_COUNT_RST = 7'd0;

    localparam logic [7:0] CODE_EMPTY = 8'hFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [10:0] tile_w;
        logic [10:0] tile_h;
        logic [6:0]  map_rows;
        logic [6:0]  map_cols;
        logic [6:0]  solid_count;
    } t_cfg;

    typedef struct packed {
        logic                is_query;
        logic [5:0]          wr_row;
        logic [5:0]          wr_col;
        logic [7:0]          wr_code;
        logic [15:0]         box_x;
        logic [15:0]         box_y;
        logic [10:0]         box_w;
        logic [10:0]         box_h;
        logic [BOUND_W-1:0]  row_start;
        logic [BOUND_W-1:0]  row_end;
        logic [BOUND_W-1:0]  col_start;
        logic [BOUND_W-1:0]  col_end;
    } t_cmd;

    typedef struct packed {
        logic [5:0] hit_row;
        logic [5:0] hit_col;
        logic [7:0] hit_code;
        logic       is_summary;
        logic       any_hit;
        logic       last;
    } t_result;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_SUMM
    } t_back_state;

    // A tile size of zero behaves as one pixel.
    function automatic logic [10:0] eff_size(logic [10:0] size);
        return (size == 11'd0) ? 11'd1 : size;
    endfunction

endpackage

`default_nettype wire

>>> hdl/tmbc_queue.sv
`default_nettype none

module tmbc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tmbc_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output tmbc_pkg::t_cmd     o_data,
    output logic               o_empty
);

    localparam int DEPTH = tmbc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tmbc_pkg::t_cmd   r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/tmbc_front.sv
`default_nettype none

module tmbc_front #(
    parameter int MAX_ROWS    = tmbc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = tmbc_pkg::MAX_COLS_DEF,
    parameter int WINDOW_SPAN = tmbc_pkg::WINDOW_SPAN_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tmbc_pkg::t_cfg     i_cfg,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_op,
    input  wire logic [5:0]         i_cell_row,
    input  wire logic [5:0]         i_cell_col,
    input  wire logic signed [7:0]  i_cell_code,
    input  wire logic [15:0]        i_box_x,
    input  wire logic [15:0]        i_box_y,
    input  wire logic [10:0]        i_box_w,
    input  wire logic [10:0]        i_box_h,
    output logic                    o_push,
    output tmbc_pkg::t_cmd          o_cmd,
    input  wire logic               i_q_full
);

    // Four divider lanes: row start, row end, column start, column end.
    localparam int LANES     = 4;
    localparam int ROW_S     = 0;
    localparam int ROW_E     = 1;
    localparam int COL_S     = 2;
    localparam int COL_E     = 3;
    localparam int NUM_W     = 18;
    localparam int DIV_ITERS = NUM_W / 2;
    localparam int CNT_W     = $clog2(DIV_ITERS);
    localparam int LIM_W     = 19;
    localparam int BW        = tmbc_pkg::BOUND_W;

    tmbc_pkg::t_front_state r_state, n_state;

    logic [NUM_W-1:0] r_num [LANES];
    logic [10:0]      r_rem [LANES];
    logic [NUM_W-1:0] n_num [LANES];
    logic [10:0]      n_rem [LANES];
    logic [10:0]      divisor [LANES];
    logic [CNT_W-1:0] r_cnt;

    logic [15:0] r_bx, r_by;
    logic [10:0] r_bw, r_bh;

    logic accept;
    logic [10:0] tw, th;
    logic [LIM_W-1:0] row_lim, col_lim;
    logic [2*BW-1:0]  row_win, col_win;
    tmbc_pkg::t_cmd   wr_cmd, qry_cmd;

    // One restoring division step: returns the quotient bit and new remainder.
    function automatic logic [11:0] div_step(logic [10:0] rem, logic nbit, logic [10:0] d);
        logic [11:0] trial;
        trial = {rem, nbit};
        if (trial >= {1'b0, d}) begin
            trial = trial - {1'b0, d};
            return {1'b1, trial[10:0]};
        end
        return {1'b0, trial[10:0]};
    endfunction

    // Clip one axis of the window to the map and to the span bound.
    function automatic logic [2*BW-1:0] clip_window(logic [NUM_W-1:0] qs,
                                                     logic [NUM_W-1:0] qe,
                                                     logic [LIM_W-1:0] lim);
        logic [LIM_W-1:0] s;
        logic [LIM_W-1:0] e;
        s = {1'b0, qs};
        e = {1'b0, qe} + LIM_W'(2);
        if (e > lim) e = lim;
        if (e > s + LIM_W'(WINDOW_SPAN)) e = s + LIM_W'(WINDOW_SPAN);
        if (s > e) s = e;
        return {s[BW-1:0], e[BW-1:0]};
    endfunction

    assign tw = tmbc_pkg::eff_size(i_cfg.tile_w);
    assign th = tmbc_pkg::eff_size(i_cfg.tile_h);

    assign divisor[ROW_S] = th;
    assign divisor[ROW_E] = th;
    assign divisor[COL_S] = tw;
    assign divisor[COL_E] = tw;

    assign o_in_stall = (r_state != tmbc_pkg::F_IDLE) || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        logic [11:0] st1;
        logic [11:0] st2;
        for (int k = 0; k < LANES; k++) begin
            st1 = div_step(r_rem[k], r_num[k][NUM_W-1], divisor[k]);
            st2 = div_step(st1[10:0], r_num[k][NUM_W-2], divisor[k]);
            n_num[k] = {r_num[k][NUM_W-3:0], st1[11], st2[11]};
            n_rem[k] = st2[10:0];
        end
    end

    assign row_lim = (LIM_W'(i_cfg.map_rows) > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                                 : LIM_W'(i_cfg.map_rows);
    assign col_lim = (LIM_W'(i_cfg.map_cols) > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS)
                                                                 : LIM_W'(i_cfg.map_cols);
    assign row_win = clip_window(r_num[ROW_S], r_num[ROW_E], row_lim);
    assign col_win = clip_window(r_num[COL_S], r_num[COL_E], col_lim);

    always_comb begin
        wr_cmd          = '0;
        wr_cmd.is_query = tmbc_pkg::OP_WRITE;
        wr_cmd.wr_row   = i_cell_row;
        wr_cmd.wr_col   = i_cell_col;
        wr_cmd.wr_code  = i_cell_code;

        qry_cmd           = '0;
        qry_cmd.is_query  = tmbc_pkg::OP_QUERY;
        qry_cmd.box_x     = r_bx;
        qry_cmd.box_y     = r_by;
        qry_cmd.box_w     = r_bw;
        qry_cmd.box_h     = r_bh;
        qry_cmd.row_start = row_win[2*BW-1:BW];
        qry_cmd.row_end   = row_win[BW-1:0];
        qry_cmd.col_start = col_win[2*BW-1:BW];
        qry_cmd.col_end   = col_win[BW-1:0];
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        o_cmd   = wr_cmd;
        unique case (r_state)
            tmbc_pkg::F_IDLE: begin
                if (accept) begin
                    if (i_op == tmbc_pkg::OP_QUERY) begin
                        n_state = tmbc_pkg::F_DIV;
                    end else begin
                        o_push = 1'b1;
                    end
                end
            end
            tmbc_pkg::F_DIV: begin
                if (r_cnt == CNT_W'(DIV_ITERS - 1)) begin
                    n_state = tmbc_pkg::F_PUSH;
                end
            end
            tmbc_pkg::F_PUSH: begin
                o_cmd = qry_cmd;
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = tmbc_pkg::F_IDLE;
                end
            end
            default: n_state = tmbc_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmbc_pkg::F_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == tmbc_pkg::F_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_op == tmbc_pkg::OP_QUERY) begin
            r_bx <= i_box_x;
            r_by <= i_box_y;
            r_bw <= i_box_w;
            r_bh <= i_box_h;
            r_num[ROW_S] <= NUM_W'(i_box_y);
            r_num[ROW_E] <= NUM_W'(i_box_y) + NUM_W'(i_box_h);
            r_num[COL_S] <= NUM_W'(i_box_x);
            r_num[COL_E] <= NUM_W'(i_box_x) + NUM_W'(i_box_w);
            for (int k = 0; k < LANES; k++) begin
                r_rem[k] <= '0;
            end
        end else if (r_state == tmbc_pkg::F_DIV) begin
            for (int k = 0; k < LANES; k++) begin
                r_num[k] <= n_num[k];
                r_rem[k] <= n_rem[k];
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/tmbc_back.sv
`default_nettype none

module tmbc_back #(
    parameter int MAX_ROWS = tmbc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = tmbc_pkg::MAX_COLS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tmbc_pkg::t_cfg  i_cfg,
    input  wire logic            i_q_empty,
    input  wire tmbc_pkg::t_cmd  i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output tmbc_pkg::t_result    o_result
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RBW   = $clog2(MAX_ROWS + 1);
    localparam int CBW   = $clog2(MAX_COLS + 1);
    localparam int PW    = tmbc_pkg::PIX_W;

    tmbc_pkg::t_back_state r_state, n_state;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd;

    logic [RBW-1:0] r_i, r_re;
    logic [CBW-1:0] r_j, r_cs, r_ce;
    logic [15:0]    r_bx, r_by;
    logic [10:0]    r_bw, r_bh;

    logic           r_s1_valid;
    logic           r_s1_sum;
    logic [RBW-1:0] r_s1_row;
    logic [CBW-1:0] r_s1_col;
    logic [PW-1:0]  r_s1_tx;
    logic [PW-1:0]  r_s1_ty;

    logic              r_out_valid;
    tmbc_pkg::t_result r_out;
    logic              r_any;

    logic          adv;
    logic          issue_cell;
    logic          issue_sum;
    logic          last_col;
    logic          last_row;
    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [10:0]   tw, th;
    logic          solid;
    logic          overlap;
    logic          hit;

    assign tw = tmbc_pkg::eff_size(i_cfg.tile_w);
    assign th = tmbc_pkg::eff_size(i_cfg.tile_h);

    // The scan only moves when the output register can take a result.
    assign adv        = !r_out_valid || !i_out_stall;
    assign issue_cell = (r_state == tmbc_pkg::B_SCAN) && adv;
    assign issue_sum  = (r_state == tmbc_pkg::B_SUMM) && adv;
    assign last_col   = ((r_j + CBW'(1)) == r_ce);
    assign last_row   = ((r_i + RBW'(1)) == r_re);

    assign wr_ok   = (int'(i_cmd.wr_row) < MAX_ROWS) && (int'(i_cmd.wr_col) < MAX_COLS);
    assign wr_addr = AW'(int'(i_cmd.wr_row) * MAX_COLS + int'(i_cmd.wr_col));
    assign rd_addr = AW'(int'(r_i) * MAX_COLS + int'(r_j));

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            tmbc_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_query == tmbc_pkg::OP_QUERY) begin
                        if (i_cmd.row_start == i_cmd.row_end ||
                            i_cmd.col_start == i_cmd.col_end) begin
                            n_state = tmbc_pkg::B_SUMM;
                        end else begin
                            n_state = tmbc_pkg::B_SCAN;
                        end
                    end
                end
            end
            tmbc_pkg::B_SCAN: begin
                if (adv && last_col && last_row) begin
                    n_state = tmbc_pkg::B_SUMM;
                end
            end
            tmbc_pkg::B_SUMM: begin
                if (adv) begin
                    n_state = tmbc_pkg::B_IDLE;
                end
            end
            default: n_state = tmbc_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmbc_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window counters and the box of the query being scanned.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.is_query == tmbc_pkg::OP_QUERY) begin
            r_i  <= RBW'(i_cmd.row_start);
            r_re <= RBW'(i_cmd.row_end);
            r_j  <= CBW'(i_cmd.col_start);
            r_cs <= CBW'(i_cmd.col_start);
            r_ce <= CBW'(i_cmd.col_end);
            r_bx <= i_cmd.box_x;
            r_by <= i_cmd.box_y;
            r_bw <= i_cmd.box_w;
            r_bh <= i_cmd.box_h;
        end else if (issue_cell) begin
            if (last_col) begin
                r_j <= r_cs;
                r_i <= r_i + RBW'(1);
            end else begin
                r_j <= r_j + CBW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.is_query == tmbc_pkg::OP_WRITE && wr_ok) begin
            r_mem[wr_addr] <= i_cmd.wr_code;
        end
        if (issue_cell) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_sum <= issue_sum;
            r_s1_row <= r_i;
            r_s1_col <= r_j;
            r_s1_tx  <= PW'(r_j) * PW'(tw);
            r_s1_ty  <= PW'(r_i) * PW'(th);
        end
    end

    assign solid   = !r_rd[7] && (r_rd[6:0] < i_cfg.solid_count);
    assign overlap = (PW'(r_bx) + PW'(r_bw) >= r_s1_tx) &&
                     (PW'(r_bx) <= r_s1_tx + PW'(tw)) &&
                     (PW'(r_by) <= r_s1_ty + PW'(th)) &&
                     (PW'(r_by) + PW'(r_bh) >= r_s1_ty);
    assign hit     = r_s1_valid && !r_s1_sum && solid && overlap;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_s1_sum) begin
                r_out.hit_row    <= '0;
                r_out.hit_col    <= '0;
                r_out.hit_code   <= tmbc_pkg::CODE_EMPTY;
                r_out.is_summary <= 1'b1;
                r_out.any_hit    <= r_any;
                r_out.last       <= 1'b1;
            end else begin
                r_out.hit_row    <= 6'(r_s1_row);
                r_out.hit_col    <= 6'(r_s1_col);
                r_out.hit_code   <= r_rd;
                r_out.is_summary <= 1'b0;
                r_out.any_hit    <= 1'b0;
                r_out.last       <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_any       <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= issue_cell || issue_sum;
            r_out_valid <= hit || (r_s1_valid && r_s1_sum);
            if (r_s1_valid && r_s1_sum) begin
                r_any <= 1'b0;
            end else if (hit) begin
                r_any <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmbc_pkg::B_SCAN) |-> (r_i < r_re && r_j < r_ce && r_j >= r_cs))
        else $error("scan position left the window");

    a_any_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_valid && r_s1_sum) |=> !r_any)
        else $error("hit flag survived into the next query");

    a_hit_is_solid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.is_summary) |->
            (!r_out.hit_code[7] && r_out.hit_code[6:0] < i_cfg.solid_count))
        else $error("hit reported on a tile that is not solid");

endmodule

`default_nettype wire

>>> hdl/tile_map_box_collision.sv
// Tile map box collision engine.
//
// The input channel (i_in_valid / o_in_stall) takes two kinds of transfer:
// a cell write (i_op = 0) stores i_cell_code at i_cell_row / i_cell_col, and
// a query (i_op = 1) tests the box i_box_x, i_box_y, i_box_w, i_box_h against
// the map. A query returns one hit transfer per solid, overlapping tile of
// its scan window in row-major order on the output channel (o_out_valid /
// i_out_stall), then a summary transfer with o_is_summary, o_any_hit and
// o_last. The front end pushes a write to the queue in the cycle it accepts
// it. A query holds the front end while it is accepted, divided by the four
// radix-4 tile-size dividers (row and column, start and end) and handed to
// the queue as a window. The back end takes each command from the queue,
// reads every cell of a query's window from the map memory in row-major
// order, then issues the summary; the window is at most 4 by 4 cells with
// the default span. Meanwhile the front end takes new transfers.
// Reset is synchronous and active low; it empties the queue and the pipeline
// but does not clear the map memory: every cell must be written before a
// query reads it. When the receiver stalls, the result register holds and the
// cell scan pauses; the queue keeps accepting until it is full.
// Configuration writes (i_cfg_we) must only happen while the block is idle.
`default_nettype none

module tile_map_box_collision #(
    parameter int MAX_ROWS    = tmbc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = tmbc_pkg::MAX_COLS_DEF,
    parameter int WINDOW_SPAN = tmbc_pkg::WINDOW_SPAN_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [10:0]        i_cfg_data,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_op,
    input  wire logic [5:0]         i_cell_row,
    input  wire logic [5:0]         i_cell_col,
    input  wire logic signed [7:0]  i_cell_code,
    input  wire logic [15:0]        i_box_x,
    input  wire logic [15:0]        i_box_y,
    input  wire logic [10:0]        i_box_w,
    input  wire logic [10:0]        i_box_h,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [5:0]              o_hit_row,
    output logic [5:0]              o_hit_col,
    output logic signed [7:0]       o_hit_code,
    output logic                    o_is_summary,
    output logic                    o_any_hit,
    output logic                    o_last
);

    tmbc_pkg::t_cfg    r_cfg;
    tmbc_pkg::t_cmd    push_cmd;
    tmbc_pkg::t_cmd    head_cmd;
    tmbc_pkg::t_result result;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;

    // Configuration registers; an index outside the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tile_w      <= tmbc_pkg::TILE_SIZE_RST;
            r_cfg.tile_h      <= tmbc_pkg::TILE_SIZE_RST;
            r_cfg.map_rows    <= tmbc_pkg::MAP_SIZE_RST;
            r_cfg.map_cols    <= tmbc_pkg::MAP_SIZE_RST;
            r_cfg.solid_count <= tmbc_pkg::SOLID_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tmbc_pkg::CFG_TILE_WIDTH:  r_cfg.tile_w      <= i_cfg_data;
                tmbc_pkg::CFG_TILE_HEIGHT: r_cfg.tile_h      <= i_cfg_data;
                tmbc_pkg::CFG_MAP_ROWS:    r_cfg.map_rows    <= i_cfg_data[6:0];
                tmbc_pkg::CFG_MAP_COLS:    r_cfg.map_cols    <= i_cfg_data[6:0];
                tmbc_pkg::CFG_SOLID_COUNT: r_cfg.solid_count <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Front end: accepts transfers, divides box edges by the tile size and
    // forms the clipped scan window.
    tmbc_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .WINDOW_SPAN (WINDOW_SPAN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_cell_row  (i_cell_row),
        .i_cell_col  (i_cell_col),
        .i_cell_code (i_cell_code),
        .i_box_x     (i_box_x),
        .i_box_y     (i_box_y),
        .i_box_w     (i_box_w),
        .i_box_h     (i_box_h),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_q_full    (q_full)
    );

    // Command queue keeps writes and queries in arrival order.
    tmbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    // Back end: owns the map memory, scans the window and drives results.
    tmbc_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_hit_row    = result.hit_row;
    assign o_hit_col    = result.hit_col;
    assign o_hit_code   = signed'(result.hit_code);
    assign o_is_summary = result.is_summary;
    assign o_any_hit    = result.any_hit;
    assign o_last       = result.last;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tmbc_pkg::*;

    // Cycles of silence (no transfer on either channel and no register write)
    // after which the run is declared hung. The longest quiet stretch in a
    // correct run is a drain pause plus a handful of register writes.
    localparam int WATCHDOG_LIMIT = 2000;

    // Pause after the last expected result before a register write or the end
    // of the run. A trailing cell write can still be in the block's queue when
    // the last result of the preceding query leaves.
    localparam int DRAIN_CYCLES = 24;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 28;

    // Index that selects no register; it fills the register slot of the rows
    // in the directed table that carry a transfer instead of a register write.
    localparam logic [2:0] CFG_NONE = 3'd7;

    typedef struct packed {
        logic              op;
        logic [5:0]        row;
        logic [5:0]        col;
        logic signed [7:0] code;
        logic [15:0]       x;
        logic [15:0]       y;
        logic [10:0]       w;
        logic [10:0]       h;
    } request_t;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_CELL,
        STEP_BOX
    } step_kind_e;

    // One row of the directed table. A register row uses reg_idx and reg_val,
    // a cell row uses row, col and code, and a box row uses x, y, w and h.
    // When typed is set, the query's outcome is written into the row: a lone
    // closing transfer whose any_hit flag is typed_any.
    typedef struct packed {
        step_kind_e        kind;
        logic [2:0]        reg_idx;
        logic [10:0]       reg_val;
        logic [5:0]        row;
        logic [5:0]        col;
        logic signed [7:0] code;
        logic [15:0]       x;
        logic [15:0]       y;
        logic [10:0]       w;
        logic [10:0]       h;
        logic              typed;
        logic              typed_any;
    } step_t;

    localparam int PLAN_LEN = 26;

    // Directed opening. Columns: kind, register, value, row, col, code,
    // x, y, w, h, typed, typed_any.
    localparam step_t PLAN [PLAN_LEN] = '{
        // Reset settings: no code is solid, so only the closing transfer comes.
        '{STEP_BOX, CFG_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0},
        // Box far past the map on both axes: the window is empty.
        '{STEP_BOX, CFG_NONE, 0, 0, 0, 0, 65535, 65535, 2047, 2047, 1, 0},
        // Every code up to 126 solid, zero tile width, widest tile height.
        '{STEP_CFG, CFG_SOLID_COUNT, 127, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{STEP_CFG, CFG_TILE_WIDTH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{STEP_CFG, CFG_TILE_HEIGHT, 2047, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // Largest solid code, empty marker, zero, the most negative code, then the far corner.
        '{STEP_CELL, CFG_NONE, 0, 0, 0, 126, 0, 0, 0, 0, 0, 0},
        '{STEP_CELL, CFG_NONE, 0, 0, 1, -1, 0, 0, 0, 0, 0, 0},
        '{STEP_CELL, CFG_NONE, 0, 0, 2, 0, 0, 0, 0, 0, 0, 0},
        '{STEP_CELL, CFG_NONE, 0, 0, 3, -128, 0, 0, 0, 0, 0, 0},
        '{STEP_CELL, CFG_NONE, 0, 63, 63, 85, 0, 0, 0, 0, 0, 0},
        // One-pixel columns: the box edge at x = 3 touches the tile at column 3.
        '{STEP_BOX, CFG_NONE, 0, 0, 0, 0, 0, 0, 3, 0, 0, 0},
        // Row count above the store size, a single column, wide flat tiles.
        '{STEP_CFG, CFG_MAP_ROWS, 127, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{STEP_CFG, CFG_MAP_COLS, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{STEP_CFG, CFG_TILE_WIDTH, 1024, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{STEP_CFG, CFG_TILE_HEIGHT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // Tall box near the bottom: the window is cut at the map edge.
        '{STEP_BOX, CFG_NONE, 0, 0, 0, 0, 0, 60, 0, 2047, 0, 0},
        // Column start beyond the single map column: nothing to scan.
        '{STEP_BOX, CFG_NONE, 0, 0, 0, 0, 65535, 63, 2047, 0, 1, 0},
        // No rows in use at all.
        '{STEP_CFG, CFG_MAP_ROWS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{STEP_BOX, CFG_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0},
        // Back to a full map; only code 0 counts as solid.
        '{STEP_CFG, CFG_MAP_ROWS, 64, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{STEP_CFG, CFG_MAP_COLS, 64, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{STEP_CFG, CFG_TILE_WIDTH, 32, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{STEP_CFG, CFG_TILE_HEIGHT, 32, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{STEP_CFG, CFG_SOLID_COUNT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{STEP_CELL, CFG_NONE, 0, 63, 62, 0, 0, 0, 0, 0, 0, 0},
        // Box in the bottom-right corner of the map.
        '{STEP_BOX, CFG_NONE, 0, 0, 0, 0, 1984, 2016, 32, 0, 0, 0}
    };

    // Inputs of the block, all known from time zero. Reset starts asserted.
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [2:0]        i_cfg_index = CFG_NONE;
    logic [10:0]       i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              i_op        = OP_WRITE;
    logic [5:0]        i_cell_row  = '0;
    logic [5:0]        i_cell_col  = '0;
    logic signed [7:0] i_cell_code = '0;
    logic [15:0]       i_box_x     = '0;
    logic [15:0]       i_box_y     = '0;
    logic [10:0]       i_box_w     = '0;
    logic [10:0]       i_box_h     = '0;
    logic              i_out_stall = 1'b0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [5:0]        o_hit_row;
    logic [5:0]        o_hit_col;
    logic signed [7:0] o_hit_code;
    logic              o_is_summary;
    logic              o_any_hit;
    logic              o_last;

    // Our own copy of the block's settings and of the tile map.
    t_cfg              shadow = '{
        tile_w: TILE_SIZE_RST,
        tile_h: TILE_SIZE_RST,
        map_rows: MAP_SIZE_RST,
        map_cols: MAP_SIZE_RST,
        solid_count: SOLID_COUNT_RST
    };
    logic signed [7:0] tile_codes [MAX_ROWS_DEF][MAX_COLS_DEF];
    bit                written [MAX_ROWS_DEF][MAX_COLS_DEF];

    // Hit and closing transfers still owed by the block, oldest first.
    t_result           hits_due [$];
    t_result           head;

    int                errors        = 0;
    int                quiet_cycles  = 0;
    int                send_gap_pct  = 10;
    int                out_stall_pct = 62;

    tile_map_box_collision DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_cell_row   (i_cell_row),
        .i_cell_col   (i_cell_col),
        .i_cell_code  (i_cell_code),
        .i_box_x      (i_box_x),
        .i_box_y      (i_box_y),
        .i_box_w      (i_box_w),
        .i_box_h      (i_box_h),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit_row    (o_hit_row),
        .o_hit_col    (o_hit_col),
        .o_hit_code   (o_hit_code),
        .o_is_summary (o_is_summary),
        .o_any_hit    (o_any_hit),
        .o_last       (o_last)
    );

    always #4 i_clk = ~i_clk;

    // A tile size of zero behaves as a one-pixel tile.
    function automatic int unsigned tile_px(input logic [10:0] size);
        return (size == 11'd0) ? 1 : size;
    endfunction

    // Row or column count in use, capped at the size of the store.
    function automatic int unsigned map_extent(input logic [6:0] count, input int unsigned cap);
        return (count > cap) ? cap : count;
    endfunction

    // Scan range along one axis: from the tile under the box's near edge up
    // to two tiles past the tile under its far edge, cut at the map edge and
    // at the window span. When the start lies beyond the map the range is
    // empty (first == stop).
    function automatic void span(input int unsigned pos, input int unsigned len,
                                 input int unsigned tile, input int unsigned limit,
                                 output int unsigned first, output int unsigned stop);
        first = pos / tile;
        stop  = (pos + len) / tile + 2;
        if (stop > limit)
            stop = limit;
        if (stop > first + WINDOW_SPAN_DEF)
            stop = first + WINDOW_SPAN_DEF;
        if (first > stop)
            first = stop;
    endfunction

    // The transfer that closes every query.
    function automatic t_result closing_item(input logic any);
        t_result res;
        res.hit_row    = '0;
        res.hit_col    = '0;
        res.hit_code   = CODE_EMPTY;
        res.is_summary = 1'b1;
        res.any_hit    = any;
        res.last       = 1'b1;
        return res;
    endfunction

    // Applies one accepted transfer to our copy of the map. A cell write only
    // updates the copy; a query queues the hits it must produce in row-major
    // order, followed by the closing transfer.
    function automatic void predict_item(input request_t rq);
        int unsigned r0, r1, c0, c1, tw, th, tx, ty, bx, by, bw, bh;
        int          code_v;
        int          hits;
        t_result     res;
        if (rq.op == OP_WRITE) begin
            tile_codes[rq.row][rq.col] = rq.code;
            written[rq.row][rq.col]    = 1'b1;
        end else begin
            tw = tile_px(shadow.tile_w);
            th = tile_px(shadow.tile_h);
            bx = rq.x;
            by = rq.y;
            bw = rq.w;
            bh = rq.h;
            span(by, bh, th, map_extent(shadow.map_rows, MAX_ROWS_DEF), r0, r1);
            span(bx, bw, tw, map_extent(shadow.map_cols, MAX_COLS_DEF), c0, c1);
            hits = 0;
            for (int unsigned r = r0; r < r1; r++) begin
                for (int unsigned c = c0; c < c1; c++) begin
                    // Negative codes, the empty marker among them, never count.
                    code_v = tile_codes[r][c];
                    tx = c * tw;
                    ty = r * th;
                    // Overlap is inclusive: touching edges count as a hit.
                    if (code_v >= 0 && code_v < int'(shadow.solid_count) &&
                        bx + bw >= tx && bx <= tx + tw &&
                        by <= ty + th && by + bh >= ty) begin
                        res.hit_row    = 6'(r);
                        res.hit_col    = 6'(c);
                        res.hit_code   = tile_codes[r][c];
                        res.is_summary = 1'b0;
                        res.any_hit    = 1'b0;
                        res.last       = 1'b0;
                        hits_due.push_back(res);
                        hits++;
                    end
                end
            end
            hits_due.push_back(closing_item(hits != 0));
        end
    endfunction

    // Random tile code: half of them solid under the current settings (when any
    // code is solid), the rest split between the empty marker, any 8-bit value,
    // and non-solid codes just above the solid range.
    function automatic logic signed [7:0] pick_code();
        int unsigned roll;
        int unsigned sc;
        roll = $urandom_range(99);
        sc   = shadow.solid_count;
        if (roll < 50 && sc != 0)
            return 8'($urandom_range(0, sc - 1));
        if (roll < 65)
            return -1;
        if (roll < 85)
            return 8'($urandom);
        return 8'($urandom_range(sc, 126));
    endfunction

    function automatic logic [10:0] pick_tile();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return 11'd0;
        if (roll < 10)
            return 11'($urandom_range(1025, 2047));
        if (roll < 20)
            return 11'($urandom_range(65, 1024));
        return 11'($urandom_range(1, 64));
    endfunction

    function automatic logic [10:0] pick_extent();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return 11'd64;
        if (roll < 80)
            return 11'($urandom_range(1, 64));
        return 11'($urandom_range(0, 127));
    endfunction

    // Places the box on one axis so that it starts over a tile inside the
    // map, now and then exactly on a tile edge or exactly a whole number of
    // tiles long, which exercises the inclusive edge test.
    function automatic void aim(input int unsigned tile, input int unsigned extent,
                                output logic [15:0] pos, output logic [10:0] len);
        int unsigned idx, p, l;
        idx = $urandom_range(0, (extent == 0) ? 63 : extent - 1);
        p   = idx * tile + (($urandom_range(3) == 0) ? 0 : $urandom_range(0, tile - 1));
        l   = ($urandom_range(3) == 0) ? $urandom_range(0, 3) * tile
                                       : $urandom_range(0, 3 * tile);
        if (p > 65535)
            p = $urandom_range(0, 65535);
        if (l > 2047)
            l = $urandom_range(0, 2047);
        pos = 16'(p);
        len = 11'(l);
    endfunction

    // Presents one transfer on the input channel and returns at the rising
    // edge that accepts it. Idle cycles are decided before valid goes up, so
    // valid never reacts to stall, and the payload holds while stalled.
    task automatic send_item(input request_t rq);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= rq.op;
        i_cell_row  <= rq.row;
        i_cell_col  <= rq.col;
        i_cell_code <= rq.code;
        i_box_x     <= rq.x;
        i_box_y     <= rq.y;
        i_box_w     <= rq.w;
        i_box_h     <= rq.h;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // The map store holds garbage until written, so before a query goes out
    // every cell of its scan window that was never written gets a code.
    task automatic fill_window(input request_t rq);
        int unsigned r0, r1, c0, c1;
        request_t    wr;
        span(rq.y, rq.h, tile_px(shadow.tile_h),
             map_extent(shadow.map_rows, MAX_ROWS_DEF), r0, r1);
        span(rq.x, rq.w, tile_px(shadow.tile_w),
             map_extent(shadow.map_cols, MAX_COLS_DEF), c0, c1);
        for (int unsigned r = r0; r < r1; r++) begin
            for (int unsigned c = c0; c < c1; c++) begin
                if (!written[r][c]) begin
                    wr      = '0;
                    wr.op   = OP_WRITE;
                    wr.row  = 6'(r);
                    wr.col  = 6'(c);
                    wr.code = pick_code();
                    send_item(wr);
                    predict_item(wr);
                end
            end
        end
    endtask

    // Drops valid, waits for every owed result, then lets a trailing cell
    // write drain out of the block.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (hits_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES)
            @(negedge i_clk);
    endtask

    // Register writes are only issued while the block is idle.
    task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TILE_WIDTH:  shadow.tile_w      = val;
            CFG_TILE_HEIGHT: shadow.tile_h      = val;
            CFG_MAP_ROWS:    shadow.map_rows    = val[6:0];
            CFG_MAP_COLS:    shadow.map_cols    = val[6:0];
            CFG_SOLID_COUNT: shadow.solid_count = val[6:0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // The receiver stalls at random; each phase sets the rate.
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < out_stall_pct);

    // Every transfer on the output channel is matched against the oldest
    // result still owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (hits_due.size() == 0) begin
                $display("%0t: unexpected result row %0d col %0d code %0d summary %0b",
                         $time, o_hit_row, o_hit_col, o_hit_code, o_is_summary);
                errors++;
            end else begin
                head = hits_due.pop_front();
                check_field("hit_row", head.hit_row, o_hit_row);
                check_field("hit_col", head.hit_col, o_hit_col);
                check_field("hit_code", int'($signed(head.hit_code)), int'(o_hit_code));
                check_field("is_summary", head.is_summary, o_is_summary);
                check_field("any_hit", head.any_hit, o_any_hit);
                check_field("last", head.last, o_last);
            end
        end
    end

    // Hang detection: any transfer or register write restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        request_t rq;
        bit       quiet;
        quiet = 1'b1;
        repeat (8)
            @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Queries first get their scan window written.
        for (int k = 0; k < PLAN_LEN; k++) begin
            if (PLAN[k].kind == STEP_CFG) begin
                if (!quiet)
                    settle();
                quiet = 1'b1;
                write_reg(PLAN[k].reg_idx, PLAN[k].reg_val);
            end else begin
                rq.op   = (PLAN[k].kind == STEP_BOX) ? OP_QUERY : OP_WRITE;
                rq.row  = PLAN[k].row;
                rq.col  = PLAN[k].col;
                rq.code = PLAN[k].code;
                rq.x    = PLAN[k].x;
                rq.y    = PLAN[k].y;
                rq.w    = PLAN[k].w;
                rq.h    = PLAN[k].h;
                if (rq.op == OP_QUERY)
                    fill_window(rq);
                send_item(rq);
                if (PLAN[k].typed)
                    hits_due.push_back(closing_item(PLAN[k].typed_any));
                else
                    predict_item(rq);
                quiet = 1'b0;
            end
        end

        // Random phases, each with fresh settings. The phases come in pairs: in the
        // first pair the sender idles lightly and the receiver heavily, in the second
        // the reverse, and in the third neither.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            send_gap_pct  = (ph < 2) ? 10 : (ph < 4) ? 62 : 0;
            out_stall_pct = (ph < 2) ? 62 : (ph < 4) ? 10 : 0;
            write_reg(CFG_TILE_WIDTH, pick_tile());
            write_reg(CFG_TILE_HEIGHT, pick_tile());
            write_reg(CFG_MAP_ROWS, pick_extent());
            write_reg(CFG_MAP_COLS, pick_extent());
            write_reg(CFG_SOLID_COUNT,
                      11'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 127)));

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Fields that the chosen operation ignores still carry noise.
                rq.row  = 6'($urandom);
                rq.col  = 6'($urandom);
                rq.code = pick_code();
                rq.x    = 16'($urandom);
                rq.y    = 16'($urandom);
                rq.w    = 11'($urandom);
                rq.h    = 11'($urandom);
                if ($urandom_range(99) < 35) begin
                    rq.op = OP_WRITE;
                end else begin
                    rq.op = OP_QUERY;
                    // Most boxes land on the map; the rest keep their fully
                    // random placement and mostly fall outside it.
                    if ($urandom_range(99) < 80) begin
                        aim(tile_px(shadow.tile_w),
                            map_extent(shadow.map_cols, MAX_COLS_DEF), rq.x, rq.w);
                        aim(tile_px(shadow.tile_h),
                            map_extent(shadow.map_rows, MAX_ROWS_DEF), rq.y, rq.h);
                    end
                    fill_window(rq);
                end
                send_item(rq);
                predict_item(rq);
            end
        end

        settle();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/tmbc_pkg.sv
hdl/tmbc_queue.sv
hdl/tmbc_front.sv
hdl/tmbc_back.sv
hdl/tile_map_box_collision.sv
tb/sv/tb_top.sv
